// ===== sv/rmts_pkg.sv =====
// Shared types and constants for the rate-monotonic tick scheduler.
package rmts_pkg;

    localparam int unsigned VAL_W  = 16;
    localparam int unsigned SLOT_W = 4;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef struct packed {
        logic [VAL_W-1:0] period;
        logic [VAL_W-1:0] cost;
        logic [VAL_W-1:0] budget;
        logic [VAL_W-1:0] phase;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// ===== sv/rmts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module rmts_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rate_monotonic_tick_scheduler_unit.sv =====
// Rate-monotonic tick scheduler: task table in RAM, one slot scanned per cycle.
// Flow: a load passes from acceptance through S_DONE to the output register; a
//   tick passes through S_SCAN, S_COMMIT and S_DONE; S_DONE waits on a stall.
// The block takes no new load or tick until it is back in S_IDLE; the slot scan
//   through the single read port of the task RAM sets the length of a tick.
// Reset: synchronous, active low; every slot reads as disabled and all zero
//   at once through per-slot valid bits, so no clearing pass is needed.
module rate_monotonic_tick_scheduler_unit
    import rmts_pkg::*;
#(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_op,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [VAL_W-1:0]  i_period,
    input  logic [VAL_W-1:0]  i_cost,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_busy_res,
    output logic [SLOT_W-1:0] o_ran_slot
);

    localparam int unsigned IW = $clog2(MAX_TASKS);      // slot index width
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);  // scan counter width
    localparam int unsigned XW = IW + SLOT_W;            // common width for slot compares

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [MAX_TASKS-1:0] r_slot_vld;   // slot written since reset; else reads as zero
    logic [CW-1:0]       r_rd_idx;      // next slot to read
    logic                r_rd_vld;      // read data returns this cycle
    logic [IW-1:0]       r_wb_idx;      // slot whose data returns this cycle
    logic                r_found;
    t_entry              r_best;        // released entry of the current winner
    logic [IW-1:0]       r_best_idx;
    logic                r_res_busy;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_o_valid;
    logic                r_o_busy;
    logic [SLOT_W-1:0]   r_o_slot;

    // RAM ports
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    logic [IW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                accept;
    logic                is_load;
    logic [XW-1:0]       slot_ext;
    logic                slot_ok;
    logic                out_free;
    t_entry              cur_entry;
    t_entry              n_entry;
    logic                cand;
    logic                last_slot;
    logic [XW-1:0]       best_ext;
    logic [SLOT_W-1:0]   best_slot4;

    rmts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Input side is open only when no item is in flight; the output register
    // decouples it from a stalled consumer.
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign is_load = (t_op'(i_op) == OP_LOAD);

    // Loads beyond the table are dropped but still answered.
    assign slot_ext = {{IW{1'b0}}, i_slot};
    assign slot_ok  = (slot_ext < XW'(MAX_TASKS));

    assign out_free = !r_o_valid || !i_stall;

    // Release step on the entry that returns from the RAM. A never-written
    // slot reads as all zero, i.e. disabled.
    always_comb begin
        cur_entry = r_slot_vld[r_wb_idx] ? t_entry'(ram_rdata) : '0;
        n_entry   = cur_entry;
        if (cur_entry.period != '0) begin
            if (cur_entry.phase == '0) begin
                n_entry.budget = cur_entry.cost;
                n_entry.phase  = cur_entry.period - VAL_W'(1);
            end else begin
                n_entry.phase  = cur_entry.phase - VAL_W'(1);
            end
        end
    end

    // Strict less-than keeps the lower slot on equal periods.
    assign cand = r_rd_vld && (n_entry.period != '0) && (n_entry.budget != '0) &&
                  (!r_found || (n_entry.period < r_best.period));

    assign last_slot = (r_wb_idx == IW'(MAX_TASKS - 1));

    assign ram_re    = (r_state == S_SCAN) && (r_rd_idx < CW'(MAX_TASKS));
    assign ram_raddr = r_rd_idx[IW-1:0];

    // One write port: load, release write-back, or the winner's budget spend.
    // The write-back always trails the read by one slot, so no overlap arises.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wb_idx;
        ram_wdata = n_entry;
        case (r_state)
            S_IDLE: begin
                ram_we    = accept && is_load && slot_ok;
                ram_waddr = slot_ext[IW-1:0];
                ram_wdata = '{period: i_period, cost: i_cost, budget: '0, phase: '0};
            end
            S_SCAN: begin
                ram_we    = r_rd_vld && (cur_entry.period != '0);
            end
            S_COMMIT: begin
                ram_we           = r_found;
                ram_waddr        = r_best_idx;
                ram_wdata        = r_best;
                ram_wdata.budget = r_best.budget - VAL_W'(1);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Report only the low four bits of the winning index.
    assign best_ext   = {{SLOT_W{1'b0}}, r_best_idx};
    assign best_slot4 = best_ext[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_slot_vld <= '0;
            r_rd_idx   <= '0;
            r_rd_vld   <= 1'b0;
            r_wb_idx   <= '0;
            r_found    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (is_load) begin
                            if (slot_ok) begin
                                r_slot_vld[slot_ext[IW-1:0]] <= 1'b1;
                            end
                            r_res_busy <= 1'b0;
                            r_res_slot <= '0;
                            r_state    <= S_DONE;
                        end else begin
                            r_rd_idx <= '0;
                            r_found  <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // advance the read pointer, track the write-back slot
                    r_rd_vld <= ram_re;
                    r_wb_idx <= r_rd_idx[IW-1:0];
                    if (ram_re) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end
                    if (cand) begin
                        r_found    <= 1'b1;
                        r_best     <= n_entry;
                        r_best_idx <= r_wb_idx;
                    end
                    if (r_rd_vld && last_slot) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_res_busy <= r_found;
                    r_res_slot <= r_found ? best_slot4 : '0;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (out_free) begin
                r_o_valid <= (r_state == S_DONE);
            end
        end

        // output payload, no reset needed
        if (out_free && (r_state == S_DONE)) begin
            r_o_busy <= r_res_busy;
            r_o_slot <= r_res_slot;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_busy_res = r_o_busy;
    assign o_ran_slot = r_o_slot;

    // Scan write-back never lands on the slot being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("task RAM read and write hit the same slot");

    // The winner committed must be enabled and have budget left.
    a_winner_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_found) |->
            (r_best.period != '0 && r_best.budget != '0))
        else $error("scheduled slot is not ready");

    // No read is still in flight once the block is back to idle.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_vld)
        else $error("stale RAM read in idle");

    // A pending result waits while the output register is blocked.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !out_free) |=> (r_state == S_DONE))
        else $error("result dropped under output stall");

    // An idle or load result carries slot zero.
    a_idle_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy_res) |-> (o_ran_slot == '0))
        else $error("idle result names a slot");

endmodule
